// ===== hw/rtl/glos_pkg.sv =====
// ----------------------------------------------------------------------------
// glos_pkg
// shared widths, types and defaults for the grid line-of-sight block
// ----------------------------------------------------------------------------
`default_nettype none

package glos_pkg;

   localparam int MAP_BITS_DEF  = 6;
   localparam int MAX_STEPS_DEF = 100;
   localparam int MAP_BITS_MAX  = 8;

   localparam int COORD_W = 14;                  // point coordinate, 1/256 tile
   localparam int SUB_W   = 4;                   // fractional bits kept, 1/16 tile
   localparam int FINE_W  = COORD_W - SUB_W;     // point in 1/16 tile
   localparam int TILE_W  = FINE_W - SUB_W;      // tile index of a point
   localparam int POS_W   = 11;                  // signed cell position while walking
   localparam int DIST_W  = SUB_W + 1;           // distance to the first edge
   localparam int MUL_W   = DIST_W + FINE_W;     // start error term
   localparam int INC_W   = FINE_W + SUB_W;      // error increment
   localparam int ERR_W   = 23;                  // running error term

   typedef logic [COORD_W-1:0]      coord_type;
   typedef logic [TILE_W-1:0]       tile_type;
   typedef logic [FINE_W-1:0]       fine_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [ERR_W-1:0]        err_type;
   typedef logic [INC_W-1:0]        inc_type;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/glos_req_if.sv =====
// ----------------------------------------------------------------------------
// glos_req_if
// request channel: map cell writes and line-of-sight queries
// ----------------------------------------------------------------------------
`default_nettype none

interface glos_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   glos_pkg::tile_type   cell_x;
   glos_pkg::tile_type   cell_y;
   logic                 cell_open;
   glos_pkg::coord_type  from_x;
   glos_pkg::coord_type  from_y;
   glos_pkg::coord_type  to_x;
   glos_pkg::coord_type  to_y;

   modport source (
      output valid, func, cell_x, cell_y, cell_open, from_x, from_y, to_x, to_y,
      input  ready
   );
   modport sink (
      input  valid, func, cell_x, cell_y, cell_open, from_x, from_y, to_x, to_y,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/glos_rsp_if.sv =====
// ----------------------------------------------------------------------------
// glos_rsp_if
// response channel: one visibility bit per query
// ----------------------------------------------------------------------------
`default_nettype none

interface glos_rsp_if;
   logic valid;
   logic ready;
   logic line_is_clear;

   modport source (output valid, line_is_clear, input ready);
   modport sink   (input valid, line_is_clear, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/glos_map_ram.sv =====
// ----------------------------------------------------------------------------
// glos_map_ram
// one-bit map memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module glos_map_ram #(
   parameter int ADDR_W = 2 * glos_pkg::MAP_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);
   logic mem_ff [2**ADDR_W];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== hw/rtl/grid_line_of_sight_top.sv =====
// ----------------------------------------------------------------------------
// grid_line_of_sight_top
// see-through map with an error-term grid walk for line-of-sight queries
// ----------------------------------------------------------------------------
//   channel   dir   payload
//   req_ch    in    func, cell_x, cell_y, cell_open, from_x, from_y, to_x, to_y
//   rsp_ch    out   line_is_clear (one transfer per query, none per write)
//
// a write updates the map as it is taken. a query runs a setup step, enters up
// to MAX_STEPS-1 cells (one map read each) and then decides.
// after reset a clearing pass zeroes the map with req_ch not ready. a finished
// answer waits in the output register; a new transfer is taken meanwhile, and a
// query that finishes while it is full holds.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_line_of_sight_top #(
   parameter int MAP_BITS  = glos_pkg::MAP_BITS_DEF,
   parameter int MAX_STEPS = glos_pkg::MAX_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   glos_req_if.sink   req_ch,
   glos_rsp_if.source rsp_ch
);
   import glos_pkg::*;

   localparam int ADDR_W = 2 * MAP_BITS;
   localparam int CNT_W  = $clog2(MAX_STEPS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SETUP = 2'd2;
   localparam logic [1:0] ST_WALK  = 2'd3;

   localparam pos_type POS_ONE = POS_W'(1);

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   fine_type          ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   pos_type           cx_ff, cx_in, cy_ff, cy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic              sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   err_type           ex_ff, ex_in, ey_ff, ey_in;
   inc_type           incx_ff, incx_in, incy_ff, incy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_clear_ff, rsp_clear_in;

   // setup arithmetic
   logic signed [FINE_W:0] dx, dy;
   fine_type               adx, ady;
   logic [DIST_W-1:0]      distx, disty;
   logic [MUL_W-1:0]       mulx, muly;

   // walk control
   logic                   req_xfer, at_goal, budget_ok, blocked, finish, out_free;
   logic                   step_x, walk_step, commit;
   pos_type                nx, ny, x_new, y_new;
   logic [CNT_W:0]         cnt_next;

   // map port
   logic                   map_we, map_wdata, map_rdata;
   logic [ADDR_W-1:0]      map_waddr, map_raddr;
   logic [MAP_BITS_MAX-1:0] wr_x, wr_y;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign dx    = signed'({1'b0, bx_ff}) - signed'({1'b0, ax_ff});
   assign dy    = signed'({1'b0, by_ff}) - signed'({1'b0, ay_ff});
   assign adx   = dx[FINE_W] ? FINE_W'(-dx) : dx[FINE_W-1:0];
   assign ady   = dy[FINE_W] ? FINE_W'(-dy) : dy[FINE_W-1:0];
   assign distx = (dx > 0) ? DIST_W'(1 << SUB_W) - DIST_W'(ax_ff[SUB_W-1:0])
                           : DIST_W'(ax_ff[SUB_W-1:0]);
   assign disty = (dy > 0) ? DIST_W'(1 << SUB_W) - DIST_W'(ay_ff[SUB_W-1:0])
                           : DIST_W'(ay_ff[SUB_W-1:0]);
   assign mulx  = MUL_W'(distx) * MUL_W'(ady);
   assign muly  = MUL_W'(disty) * MUL_W'(adx);

   assign at_goal   = (cx_ff == gx_ff) && (cy_ff == gy_ff);
   assign cnt_next  = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign budget_ok = cnt_next < (CNT_W+1)'(MAX_STEPS);
   assign blocked   = pend_ff && !map_rdata;
   assign finish    = blocked || at_goal || !budget_ok;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign walk_step = (state_ff == ST_WALK) && !finish;
   assign commit    = (state_ff == ST_WALK) && finish && out_free;

   assign step_x = ex_ff < ey_ff;
   assign nx     = sx_neg_ff ? cx_ff - POS_ONE : cx_ff + POS_ONE;
   assign ny     = sy_neg_ff ? cy_ff - POS_ONE : cy_ff + POS_ONE;
   assign x_new  = step_x ? nx : cx_ff;
   assign y_new  = step_x ? cy_ff : ny;

   assign map_raddr = {y_new[MAP_BITS-1:0], x_new[MAP_BITS-1:0]};
   assign wr_x      = MAP_BITS_MAX'(req_ch.cell_x);
   assign wr_y      = MAP_BITS_MAX'(req_ch.cell_y);

   always_comb begin
      map_we    = 1'b0;
      map_waddr = clr_ff;
      map_wdata = 1'b0;
      if (state_ff == ST_CLEAR) begin
         map_we = 1'b1;
      end else if (req_xfer && req_ch.func == FUNC_WRITE) begin
         map_we    = 1'b1;
         map_waddr = {wr_y[MAP_BITS-1:0], wr_x[MAP_BITS-1:0]};
         map_wdata = req_ch.cell_open;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      incx_in      = incx_ff;
      incy_in      = incy_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_clear_in = rsp_clear_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer && req_ch.func == FUNC_QUERY) begin
               ax_in    = req_ch.from_x[COORD_W-1:SUB_W];
               ay_in    = req_ch.from_y[COORD_W-1:SUB_W];
               bx_in    = req_ch.to_x[COORD_W-1:SUB_W];
               by_in    = req_ch.to_y[COORD_W-1:SUB_W];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cx_in     = POS_W'(ax_ff[FINE_W-1:SUB_W]);
            cy_in     = POS_W'(ay_ff[FINE_W-1:SUB_W]);
            gx_in     = POS_W'(bx_ff[FINE_W-1:SUB_W]);
            gy_in     = POS_W'(by_ff[FINE_W-1:SUB_W]);
            sx_neg_in = !(dx > 0);
            sy_neg_in = !(dy > 0);
            ex_in     = ERR_W'(mulx);
            ey_in     = ERR_W'(muly);
            incx_in   = {ady, SUB_W'(0)};
            incy_in   = {adx, SUB_W'(0)};
            cnt_in    = '0;
            pend_in   = 1'b0;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (walk_step) begin
               cnt_in  = cnt_next[CNT_W-1:0];
               pend_in = 1'b1;
               if (step_x) begin
                  cx_in = nx;
                  ex_in = ex_ff + ERR_W'(incx_ff);
               end else begin
                  cy_in = ny;
                  ey_in = ey_ff + ERR_W'(incy_ff);
               end
            end else if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_clear_in = !blocked;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      sx_neg_ff    <= sx_neg_in;
      sy_neg_ff    <= sy_neg_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      incx_ff      <= incx_in;
      incy_ff      <= incy_in;
      cnt_ff       <= cnt_in;
      rsp_clear_ff <= rsp_clear_in;
   end

   glos_map_ram #(
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (walk_step),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.line_is_clear = rsp_clear_ff;
endmodule

`default_nettype wire
